### hw/rtl/mri_pkg.sv
// Shared constants, op codes, slot-table interface types and the pointer increment helper.
`default_nettype none

package mri_pkg;

  localparam int RING_DEPTH   = 64;
  localparam int READER_SLOTS = 8;

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SLOT_W = (READER_SLOTS > 1) ? $clog2(READER_SLOTS) : 1;
  localparam int CLR_N  = (READER_SLOTS < RING_DEPTH) ? READER_SLOTS : RING_DEPTH;

  localparam int ID_W   = 64;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 8;
  localparam int RUN_W  = 7;
  localparam int AGE_W  = 32;

  typedef enum logic [2:0] {
    OP_PUSH      = 3'd0,
    OP_SUB       = 3'd1,
    OP_RD_UNREAD = 3'd2,
    OP_RD_LATEST = 3'd3,
    OP_CLEAR     = 3'd4
  } op_t;

  // requests from the sequencer to the slot table
  typedef struct packed {
    logic sub_go;
    logic clr;
    logic upd_en;
  } slot_req_t;

  // lookup result and status back from the slot table
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic [PTR_W-1:0]  hit_rpos;
    logic              busy;
  } slot_st_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/mri_ring_mem.sv
// Byte ring storage: synchronous memory with per-entry valid bits.
`default_nettype none

module mri_ring_mem
  import mri_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              we,
  input  wire logic [PTR_W-1:0]  waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [PTR_W-1:0]  raddr,
  input  wire logic              clr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0]     mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld;
  logic [BYTE_W-1:0]     q_byte;
  logic                  q_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_byte <= mem[raddr];
    end
  end

  // entries never written, or wiped by clear, read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (re) begin
        q_vld <= vld[raddr];
      end
      if (clr) begin
        vld[CLR_N-1:0] <= '0;
      end else if (we) begin
        vld[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = q_vld ? q_byte : '0;

endmodule

`default_nettype wire

### hw/rtl/mri_slot_table.sv
// Reader slot table: id match, LRU aging, fill and oldest-slot scan.
`default_nettype none

module mri_slot_table
  import mri_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire slot_req_t        req,
  input  wire logic [ID_W-1:0]  id,
  input  wire logic [PTR_W-1:0] wp,
  output slot_st_t              st
);

  logic [ID_W-1:0]   slot_ids  [READER_SLOTS];
  logic [AGE_W-1:0]  slot_ages [READER_SLOTS];
  logic [PTR_W-1:0]  slot_rpos [READER_SLOTS];

  logic              scanning;
  logic [SLOT_W-1:0] scan_idx;
  logic [AGE_W-1:0]  best_age;
  logic [SLOT_W-1:0] best_idx;

  logic [READER_SLOTS-1:0] match_vec;
  logic                    hit;
  logic [SLOT_W-1:0]       hit_idx;
  logic                    empty_any;
  logic [SLOT_W-1:0]       empty_idx;
  logic                    scan_ge;
  logic [SLOT_W-1:0]       scan_win;

  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    empty_any = 1'b0;
    empty_idx = '0;
    for (int i = READER_SLOTS - 1; i >= 0; i--) begin
      match_vec[i] = (id != '0) && (slot_ids[i] == id);
      if (match_vec[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (slot_ids[i] == '0) begin
        empty_any = 1'b1;
        empty_idx = SLOT_W'(i);
      end
    end
  end

  // ties go to the higher index
  assign scan_ge  = slot_ages[scan_idx] >= best_age;
  assign scan_win = scan_ge ? scan_idx : best_idx;

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      for (int i = 0; i < READER_SLOTS; i++) begin
        slot_ids[i]  <= '0;
        slot_ages[i] <= '0;
        slot_rpos[i] <= '0;
      end
      scanning <= 1'b0;
      scan_idx <= '0;
      best_age <= '0;
      best_idx <= '0;
    end else if (req.sub_go && id != '0) begin
      for (int i = 0; i < READER_SLOTS; i++) begin
        if (match_vec[i]) begin
          slot_ages[i] <= '0;
        end else if (slot_ids[i] != '0 && slot_ages[i] != '1) begin
          slot_ages[i] <= slot_ages[i] + 1'b1;
        end
      end
      if (!hit) begin
        if (empty_any) begin
          slot_ids[empty_idx]  <= id;
          slot_ages[empty_idx] <= '0;
          slot_rpos[empty_idx] <= wp;
        end else begin
          scanning <= 1'b1;
          scan_idx <= '0;
          best_age <= '0;
          best_idx <= '0;
        end
      end
    end else if (scanning) begin
      if (scan_ge) begin
        best_age <= slot_ages[scan_idx];
        best_idx <= scan_idx;
      end
      if (scan_idx == SLOT_W'(READER_SLOTS - 1)) begin
        slot_ids[scan_win]  <= id;
        slot_ages[scan_win] <= '0;
        slot_rpos[scan_win] <= wp;
        scanning            <= 1'b0;
      end else begin
        scan_idx <= scan_idx + 1'b1;
      end
    end else if (req.upd_en) begin
      slot_rpos[hit_idx] <= wp;
    end
  end

  assign st.hit      = hit;
  assign st.hit_idx  = hit_idx;
  assign st.hit_rpos = slot_rpos[hit_idx];
  assign st.busy     = scanning;

endmodule

`default_nettype wire

### hw/rtl/multi_reader_input_ring.sv
// Top level: op sequencer, read-run engine and output register of the reader ring.
//
// Input channel (in_valid/in_ready) takes one op per transfer: push, subscribe,
// read unread, read latest or clear. Output channel (out_valid/out_ready) carries
// result items: one per delivered byte, or one status item (length error, unknown
// reader, empty run). Push, subscribe, clear and unknown op codes give no result.
// Timing:
//   push, clear, unknown op: handled in idle, a new op may follow every cycle.
//   subscribe: decode state, then subscribe state; when the table is full and
//     the id is new, the oldest slot is found by a scan of one slot per cycle.
//   reads: decode cycle, then one ring memory read per byte; the first result
//     is read in decode and loaded into the output register in the run state,
//     then one byte per cycle while the receiver takes them. The ring's single
//     read port sets that pace. The next op waits until the last result is loaded.
// A stalled receiver holds the output register and the run waits with it; the
// ring's read data is held until it can be loaded.
// Reset (synchronous, rst high): slots empty, write pointer zero, the ring reads
// as zeros, output register empty. No clearing pass is needed.
`default_nettype none

module multi_reader_input_ring
  import mri_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        op,
  input  wire logic [ID_W-1:0]   reader_id,
  input  wire logic [BYTE_W-1:0] in_byte,
  input  wire logic [LEN_W-1:0]  req_len,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [BYTE_W-1:0] out_byte,
  output logic                   byte_valid,
  output logic      [RUN_W-1:0]  run_count,
  output logic                   reader_found,
  output logic                   len_error,
  output logic                   last
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_SUB  = 5'b00100,
    S_STAT = 5'b01000,
    S_RUN  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [PTR_W-1:0] wp;
  logic [2:0]       op_r;
  logic [ID_W-1:0]  id_r;
  logic [LEN_W-1:0] len_r;

  // run / status context
  logic [PTR_W-1:0] rd_pos;
  logic [CNT_W-1:0] issue_left;
  logic [CNT_W-1:0] run_n;
  logic             run_found;
  logic             st_found;
  logic             st_err;

  logic in_xfer;
  logic out_free;

  // ring memory port
  logic              mem_we;
  logic              mem_re;
  logic [PTR_W-1:0]  mem_raddr;
  logic              mem_clr;
  logic [BYTE_W-1:0] mem_rdata;

  slot_req_t slot_req;
  slot_st_t  slot_st;

  // decode-cycle arithmetic
  logic             len_ok;
  logic [CNT_W-1:0] len_c;
  logic [CNT_W-1:0] unread;
  logic [CNT_W-1:0] n_unread;
  logic [PTR_W-1:0] latest_start;

  // decode results
  logic             go_run;
  logic [PTR_W-1:0] go_start;
  logic [CNT_W-1:0] go_n;
  logic             go_found;
  logic             go_stat;
  logic             go_stat_found;
  logic             go_stat_err;

  logic load_run;
  logic load_stat;

  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign len_ok = (len_r <= LEN_W'(RING_DEPTH));
  assign len_c  = CNT_W'(len_r);

  always_comb begin
    if (wp >= slot_st.hit_rpos) begin
      unread = CNT_W'(wp - slot_st.hit_rpos);
    end else begin
      unread = CNT_W'(wp) + CNT_W'(RING_DEPTH) - CNT_W'(slot_st.hit_rpos);
    end
    n_unread = (unread < len_c) ? unread : len_c;
    if (CNT_W'(wp) >= len_c) begin
      latest_start = PTR_W'(CNT_W'(wp) - len_c);
    end else begin
      latest_start = PTR_W'(CNT_W'(wp) + CNT_W'(RING_DEPTH) - len_c);
    end
  end

  // what the decode cycle does with the captured op
  always_comb begin
    go_run        = 1'b0;
    go_start      = latest_start;
    go_n          = len_c;
    go_found      = 1'b0;
    go_stat       = 1'b0;
    go_stat_found = 1'b0;
    go_stat_err   = 1'b0;
    slot_req      = '0;
    case (op_r)
      OP_SUB: begin
        slot_req.sub_go = (state == S_DEC);
      end
      OP_RD_LATEST: begin
        if (!len_ok) begin
          go_stat     = 1'b1;
          go_stat_err = 1'b1;
        end else if (len_c == '0) begin
          go_stat = 1'b1;
        end else begin
          go_run = 1'b1;
        end
      end
      OP_RD_UNREAD: begin
        if (!len_ok) begin
          go_stat     = 1'b1;
          go_stat_err = 1'b1;
        end else if (!slot_st.hit) begin
          go_stat = 1'b1;
        end else begin
          slot_req.upd_en = (state == S_DEC);
          go_start        = slot_st.hit_rpos;
          go_n            = n_unread;
          go_found        = 1'b1;
          if (n_unread == '0) begin
            go_stat       = 1'b1;
            go_stat_found = 1'b1;
          end else begin
            go_run = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    slot_req.clr = in_xfer && (op == OP_CLEAR);
  end

  assign load_run  = (state == S_RUN) && out_free;
  assign load_stat = (state == S_STAT) && out_free;

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_raddr  = rd_pos;
    case (state)
      S_IDLE: begin
        if (in_xfer && (op == OP_SUB || op == OP_RD_UNREAD || op == OP_RD_LATEST)) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (op_r == OP_SUB) begin
          state_next = S_SUB;
        end else if (go_run) begin
          mem_re     = 1'b1;
          mem_raddr  = go_start;
          state_next = S_RUN;
        end else if (go_stat) begin
          state_next = S_STAT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SUB: begin
        if (!slot_st.busy) begin
          state_next = S_IDLE;
        end
      end
      S_STAT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        if (out_free) begin
          if (issue_left != '0) begin
            mem_re = 1'b1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign mem_we  = in_xfer && (op == OP_PUSH);
  assign mem_clr = in_xfer && (op == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
    end else begin
      state <= state_next;
      if (mem_we) begin
        wp <= ptr_inc(wp);
      end
    end
  end

  // captured op and run context
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= op;
      id_r  <= reader_id;
      len_r <= req_len;
    end
    if (state == S_DEC) begin
      rd_pos     <= ptr_inc(go_start);
      issue_left <= go_n - 1'b1;
      run_n      <= go_n;
      run_found  <= go_found;
      st_found   <= go_stat_found;
      st_err     <= go_stat_err;
    end else if (mem_re) begin
      rd_pos     <= ptr_inc(rd_pos);
      issue_left <= issue_left - 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_run || load_stat) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_run) begin
      out_byte     <= mem_rdata;
      byte_valid   <= 1'b1;
      run_count    <= RUN_W'(run_n);
      reader_found <= run_found;
      len_error    <= 1'b0;
      last         <= (issue_left == '0);
    end else if (load_stat) begin
      out_byte     <= '0;
      byte_valid   <= 1'b0;
      run_count    <= '0;
      reader_found <= st_found;
      len_error    <= st_err;
      last         <= 1'b1;
    end
  end

  mri_ring_mem u_ring (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (wp),
    .wdata (in_byte),
    .re    (mem_re),
    .raddr (mem_raddr),
    .clr   (mem_clr),
    .rdata (mem_rdata)
  );

  mri_slot_table u_slots (
    .clk (clk),
    .rst (rst),
    .req (slot_req),
    .id  (id_r),
    .wp  (wp),
    .st  (slot_st)
  );

  // a status item always closes its run and carries no byte count
  a_stat_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last && run_count == '0)
    else $error("status result without last or with a count");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && len_error |-> !byte_valid && !reader_found)
    else $error("length error result carries data");

  a_run_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN && !out_free |=> state == S_RUN && $stable(issue_left))
    else $error("read run advanced while output stalled");

  a_scan_sub: assert property (@(posedge clk) disable iff (rst)
    slot_st.busy |-> state == S_SUB)
    else $error("slot scan outside subscribe");

  a_no_write_in_run: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> !mem_we && !mem_clr)
    else $error("ring modified during a read run");

endmodule

`default_nettype wire

### tb/multi_reader_input_ring_tb.sv
// Self-checking testbench for the multi-reader byte ring with its subscriber slot table.
`default_nettype none

module multi_reader_input_ring_tb;
  import mri_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // op codes the block does not decode; they must pass without any result
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  localparam logic [ID_W-1:0] ID_NONE = '0;
  localparam logic [ID_W-1:0] ID_ALL  = '1;

  // read-run result as it appears on the output channel
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              data_ok;
    logic [RUN_W-1:0]  count;
    logic              found;
    logic              err;
    logic              tail;
  } run_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        op = OP_PUSH;
  logic [ID_W-1:0]   reader_id = '0;
  logic [BYTE_W-1:0] in_byte = '0;
  logic [LEN_W-1:0]  req_len = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic [RUN_W-1:0]  run_count;
  logic              reader_found;
  logic              len_error;
  logic              last;

  multi_reader_input_ring u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .reader_id    (reader_id),
    .in_byte      (in_byte),
    .req_len      (req_len),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_count    (run_count),
    .reader_found (reader_found),
    .len_error    (len_error),
    .last         (last)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the ring and slot table, updated at every input transfer.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0] ring_mem  [RING_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [ID_W-1:0]   slot_id   [READER_SLOTS];
  logic [AGE_W-1:0]  slot_age  [READER_SLOTS];
  logic [PTR_W-1:0]  slot_rpos [READER_SLOTS];

  run_beat_t read_beats_due[$];

  int errors       = 0;
  int ops_sent     = 0;
  int beats_seen   = 0;
  int idle_pct     = 0;   // sender: chance per cycle of holding valid low
  int stall_pct    = 0;   // receiver: chance per cycle of holding ready low

  logic [ID_W-1:0] id_pool [12];

  function automatic void queue_beat(input logic [BYTE_W-1:0] data, input logic data_ok,
                                     input int count, input logic found, input logic err,
                                     input logic tail);
    run_beat_t b;
    b.data    = data;
    b.data_ok = data_ok;
    b.count   = RUN_W'(count);
    b.found   = found;
    b.err     = err;
    b.tail    = tail;
    read_beats_due.push_back(b);
  endfunction

  // Applies one accepted op to the shadow state and queues the beats it owes.
  task automatic ring_apply_op(input logic [2:0] code, input logic [ID_W-1:0] id,
                               input logic [BYTE_W-1:0] data, input logic [LEN_W-1:0] len);
    int i;
    int hit;
    int free_slot;
    int pos;
    int n;
    int unread;
    logic matched;
    logic [AGE_W-1:0] oldest;
    case (code)
      OP_PUSH: begin
        ring_mem[wr_ptr] = data;
        wr_ptr = PTR_W'((int'(wr_ptr) + 1) % RING_DEPTH);
      end
      OP_SUB: begin
        if (id != ID_NONE) begin
          matched   = 1'b0;
          free_slot = -1;
          // age every other occupied slot, saturating
          for (i = 0; i < READER_SLOTS; i++) begin
            if (slot_id[i] == id) begin
              slot_age[i] = '0;
              matched     = 1'b1;
            end else if (slot_id[i] != ID_NONE && slot_age[i] != '1) begin
              slot_age[i] = slot_age[i] + 1'b1;
            end
            if (free_slot < 0 && slot_id[i] == ID_NONE) free_slot = i;
          end
          if (!matched) begin
            // table full: evict the oldest, ties to the higher index
            if (free_slot < 0) begin
              oldest    = '0;
              free_slot = 0;
              for (i = 0; i < READER_SLOTS; i++) begin
                if (slot_age[i] >= oldest) begin
                  oldest    = slot_age[i];
                  free_slot = i;
                end
              end
            end
            slot_id[free_slot]   = id;
            slot_age[free_slot]  = '0;
            slot_rpos[free_slot] = wr_ptr;
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < READER_SLOTS; i++) begin
          if (i < RING_DEPTH) ring_mem[i] = '0;
          slot_id[i]   = '0;
          slot_age[i]  = '0;
          slot_rpos[i] = '0;
        end
      end
      OP_RD_UNREAD, OP_RD_LATEST: begin
        if (int'(len) > RING_DEPTH) begin
          queue_beat('0, 1'b0, 0, 1'b0, 1'b1, 1'b1);
        end else if (code == OP_RD_LATEST) begin
          if (len == 0) begin
            queue_beat('0, 1'b0, 0, 1'b0, 1'b0, 1'b1);
          end else begin
            pos = (int'(wr_ptr) + RING_DEPTH - int'(len)) % RING_DEPTH;
            for (i = 0; i < int'(len); i++) begin
              queue_beat(ring_mem[pos], 1'b1, int'(len), 1'b0, 1'b0, i == int'(len) - 1);
              pos = (pos + 1) % RING_DEPTH;
            end
          end
        end else begin
          hit = -1;
          if (id != ID_NONE) begin
            for (i = 0; i < READER_SLOTS; i++) begin
              if (hit < 0 && slot_id[i] == id) hit = i;
            end
          end
          if (hit < 0) begin
            queue_beat('0, 1'b0, 0, 1'b0, 1'b0, 1'b1);
          end else begin
            pos    = int'(slot_rpos[hit]);
            unread = (int'(wr_ptr) + RING_DEPTH - pos) % RING_DEPTH;
            n      = (unread < int'(len)) ? unread : int'(len);
            // whatever is not delivered is dropped: the reader jumps to the head
            slot_rpos[hit] = wr_ptr;
            if (n == 0) begin
              queue_beat('0, 1'b0, 0, 1'b1, 1'b0, 1'b1);
            end else begin
              for (i = 0; i < n; i++) begin
                queue_beat(ring_mem[pos], 1'b1, n, 1'b1, 1'b0, i == n - 1);
                pos = (pos + 1) % RING_DEPTH;
              end
            end
          end
        end
      end
      default: ;  // unused codes change nothing
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Called at a falling edge; returns at the falling edge after the
  // transfer. Valid stays high between back-to-back items.
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [2:0] code, input logic [ID_W-1:0] id,
                         input logic [BYTE_W-1:0] data, input logic [LEN_W-1:0] len);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid  <= 1'b1;
    op        <= code;
    reader_id <= id;
    in_byte   <= data;
    req_len   <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ring_apply_op(code, id, data, len);
    ops_sent++;
    @(negedge clk);
  endtask

  function automatic logic [ID_W-1:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  // push with random don't-care fields
  task automatic push_byte(input logic [BYTE_W-1:0] data);
    send_op(OP_PUSH, rand_id(), data, LEN_W'($urandom));
  endtask

  // hold off new input until every owed beat has been taken
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (read_beats_due.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready, and a per-beat compare against the oldest owed beat.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    run_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (read_beats_due.size() == 0) begin
        $error("result transfer with nothing owed (out_byte %0h, last %0b)", out_byte, last);
        errors++;
      end else begin
        want = read_beats_due.pop_front();
        beats_seen++;
        if (out_byte !== want.data) begin
          $error("out_byte mismatch: expected %0h, actual %0h", want.data, out_byte);
          errors++;
        end
        if (byte_valid !== want.data_ok) begin
          $error("byte_valid mismatch: expected %0b, actual %0b", want.data_ok, byte_valid);
          errors++;
        end
        if (run_count !== want.count) begin
          $error("run_count mismatch: expected %0d, actual %0d", want.count, run_count);
          errors++;
        end
        if (reader_found !== want.found) begin
          $error("reader_found mismatch: expected %0b, actual %0b", want.found, reader_found);
          errors++;
        end
        if (len_error !== want.err) begin
          $error("len_error mismatch: expected %0b, actual %0b", want.err, len_error);
          errors++;
        end
        if (last !== want.tail) begin
          $error("last mismatch: expected %0b, actual %0b", want.tail, last);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edge cases: id zero, empty and full-depth runs, length errors, zero-length
  // read with unread data, truncated read, unknown reader, clear, unused codes.
  task automatic test_edge_cases();
    logic [2:0] code;
    idle_pct  = 0;
    stall_pct = 0;
    send_op(OP_RD_UNREAD, ID_NONE, '0, 8'd4);              // id zero is never found
    send_op(OP_RD_LATEST, rand_id(), '0, 8'd0);            // empty run
    send_op(OP_RD_LATEST, rand_id(), '0, LEN_W'(RING_DEPTH));      // whole ring after reset
    send_op(OP_RD_LATEST, rand_id(), '0, LEN_W'(RING_DEPTH + 1));  // just past depth
    send_op(OP_RD_UNREAD, ID_ALL, '0, 8'hFF);              // length error wins over lookup
    send_op(OP_SUB, ID_NONE, '0, '0);                      // ignored
    send_op(OP_SUB, ID_ALL, '0, '0);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hA5);
    send_op(OP_RD_UNREAD, ID_ALL, '0, 8'd0);               // delivers nothing, index jumps
    send_op(OP_RD_UNREAD, ID_ALL, '0, LEN_W'(RING_DEPTH)); // found, nothing unread
    push_byte(8'h5A);
    push_byte(8'h01);
    send_op(OP_RD_UNREAD, ID_ALL, '0, 8'd1);               // one byte, the other dropped
    send_op(OP_RD_UNREAD, ID_W'(1), '0, 8'd8);             // unknown reader
    send_op(OP_RD_LATEST, rand_id(), '0, 8'd3);
    send_op(OP_CLEAR, rand_id(), 8'hFF, 8'hFF);
    send_op(OP_RD_UNREAD, ID_ALL, '0, 8'd8);               // slot gone after clear
    send_op(OP_RD_LATEST, rand_id(), '0, 8'd8);            // low bytes zeroed, pointer kept
    for (code = OP_UNUSED_LO; code <= OP_UNUSED_HI && code >= OP_UNUSED_LO; code++) begin
      send_op(code, rand_id(), BYTE_W'($urandom), LEN_W'($urandom));
    end
    send_op(OP_RD_LATEST, rand_id(), '0, LEN_W'(RING_DEPTH));
  endtask

  // Fill the table, refresh one reader, then force evictions and read each
  // surviving reader so that stale and fresh read positions both show up.
  task automatic test_slot_replacement();
    int i;
    idle_pct  = 6;
    stall_pct = 6;
    send_op(OP_CLEAR, rand_id(), '0, '0);
    for (i = 1; i <= READER_SLOTS; i++) begin
      send_op(OP_SUB, ID_W'(i), '0, '0);
      push_byte(BYTE_W'(8'h10 + i));
    end
    send_op(OP_SUB, ID_W'(1), '0, '0);                     // refresh the oldest
    for (i = READER_SLOTS + 1; i <= READER_SLOTS + 3; i++) begin
      send_op(OP_SUB, ID_W'(i), '0, '0);                   // evicts the least recent
      push_byte(BYTE_W'($urandom));
    end
    for (i = 1; i <= READER_SLOTS + 3; i++) begin
      send_op(OP_RD_UNREAD, ID_W'(i), '0, LEN_W'(RING_DEPTH));
    end
  endtask

  // Push past the ring size so old data is overwritten under a reader.
  task automatic test_ring_overwrite();
    int i;
    idle_pct  = 0;
    stall_pct = 30;
    send_op(OP_SUB, ID_ALL, '0, '0);
    send_op(OP_SUB, ID_W'(2), '0, '0);
    for (i = 0; i < RING_DEPTH + 6; i++) push_byte(BYTE_W'($urandom));
    send_op(OP_RD_UNREAD, ID_ALL, '0, LEN_W'(RING_DEPTH));
    for (i = 0; i < 10; i++) push_byte(BYTE_W'($urandom));
    send_op(OP_RD_UNREAD, ID_W'(2), '0, 8'd5);             // truncated, rest dropped
    send_op(OP_RD_UNREAD, ID_W'(2), '0, LEN_W'(RING_DEPTH));
    send_op(OP_RD_LATEST, rand_id(), '0, LEN_W'(RING_DEPTH));
    send_op(OP_RD_LATEST, rand_id(), '0, 8'd1);
  endtask

  // Random op mix over a small pool of readers so lookups hit and the table
  // churns; some unknown ids, clears, unused codes and over-length requests.
  task automatic random_mix(input int n_ops, input bit pause_mid);
    int i;
    int pick;
    int lsel;
    logic [2:0] code;
    logic [ID_W-1:0] id;
    logic [LEN_W-1:0] len;
    for (i = 0; i < n_ops; i++) begin
      if (pause_mid && i == n_ops / 2) hold_until_drained();
      pick = $urandom_range(99);
      id   = ($urandom_range(9) != 0) ? id_pool[$urandom_range(11)] : rand_id();
      if ($urandom_range(49) == 0) id = ID_NONE;
      lsel = $urandom_range(99);
      if (lsel < 60)      len = LEN_W'($urandom_range(12));
      else if (lsel < 90) len = LEN_W'($urandom_range(RING_DEPTH));
      else                len = LEN_W'($urandom_range(255, RING_DEPTH + 1));
      if (pick < 38)      code = OP_PUSH;
      else if (pick < 52) code = OP_SUB;
      else if (pick < 74) code = OP_RD_UNREAD;
      else if (pick < 92) code = OP_RD_LATEST;
      else if (pick < 95) code = OP_CLEAR;
      else                code = 3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      send_op(code, id, BYTE_W'($urandom), len);
    end
  endtask

  task automatic test_random_traffic();
    int i;
    for (i = 0; i < 12; i++) begin
      do id_pool[i] = rand_id(); while (id_pool[i] == ID_NONE);
    end
    idle_pct = 0;  stall_pct = 0;  random_mix(35, 1'b0);
    idle_pct = 58; stall_pct = 0;  random_mix(35, 1'b1);
    idle_pct = 0;  stall_pct = 58; random_mix(35, 1'b0);
    idle_pct = 6;  stall_pct = 6;  random_mix(35, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    for (i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
    for (i = 0; i < READER_SLOTS; i++) begin
      slot_id[i]   = '0;
      slot_age[i]  = '0;
      slot_rpos[i] = '0;
    end
    wr_ptr = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_slot_replacement();
    test_ring_overwrite();
    test_random_traffic();

    // drain, then let the clock run on with the receiver always ready
    hold_until_drained();
    stall_pct = 0;
    repeat (16) @(negedge clk);

    $display("Covered %0d input transfers (all op codes, length errors, wrap, evictions)",
             ops_sent);
    $display("and %0d checked result transfers under four idle/stall mixes.", beats_seen);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
